[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL modules.
// Each macro expects clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/dq_pkg.sv]
`default_nettype none

package dq_pkg;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef logic [OP_W-1:0]            op_t;
  typedef logic signed [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0]        status_t;

  localparam op_t OP_PUSH_FRONT = 3'd0;
  localparam op_t OP_PUSH_BACK  = 3'd1;
  localparam op_t OP_POP_FRONT  = 3'd2;
  localparam op_t OP_POP_BACK   = 3'd3;
  localparam op_t OP_READ_ALL   = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic    push_front;  // write at head-1, move head back, count up
    logic    push_back;   // write at head+count, count up
    logic    pop_front;   // read at head, move head on, count down
    logic    pop_back;    // read at head+count-1, count down
    logic    dump_start;  // read at head, clear scan index
    logic    dump_next;   // read at head+index+1, advance scan index
    logic    load;        // load the output register
    logic    from_mem;    // payload from read data, else zero
    logic    last_scan;   // last flag from scan end, else one
    status_t status;
  } dq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_last;      // scan index is on the back entry
  } dq_sts_t;

endpackage

`default_nettype wire

[hw/rtl/dq_if.sv]
`default_nettype none

interface dq_in_if;
  import dq_pkg::*;
  logic   valid;
  logic   ready;
  op_t    operation;
  value_t value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface dq_out_if;
  import dq_pkg::*;
  logic    valid;
  logic    ready;
  value_t  result_value;
  status_t status;
  logic    last;

  modport source (output valid, output result_value, output status, output last,
                  input ready);
  modport sink   (input valid, input result_value, input status, input last,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/dq_datapath.sv]
`default_nettype none

module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire dq_cmd_t cmd,
  input  wire value_t  value,
  output dq_sts_t      sts,
  output value_t       result_value,
  output status_t      status,
  output logic         last
);

`include "assert_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_data;

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] scan_idx;

  logic [AW-1:0] head_dec, head_inc;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en, rd_en;
  logic signed [EW-1:0] in_wide, rd_wide;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CW-1:0] offs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(offs);
    if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
    return sum[AW-1:0];
  endfunction

  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  assign sts.empty     = (count == '0);
  assign sts.full      = (count == CW'(DEPTH));
  assign sts.scan_last = ((CW'(scan_idx) + CW'(1)) == count);

  assign in_wide = EW'(value);
  assign rd_wide = EW'(rd_data);

  assign wr_en   = cmd.push_front || cmd.push_back;
  assign wr_addr = cmd.push_front ? head_dec : ring_add(head, count);

  assign rd_en = cmd.pop_front || cmd.pop_back || cmd.dump_start || cmd.dump_next;

  always_comb begin
    priority if (cmd.pop_back) begin
      rd_addr = ring_add(head, count - CW'(1));
    end else if (cmd.dump_next) begin
      rd_addr = ring_add(head, CW'(scan_idx) + CW'(1));
    end else begin
      rd_addr = head;
    end
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    priority if (cmd.push_front) begin
      head_next  = head_dec;
      count_next = count + CW'(1);
    end else if (cmd.push_back) begin
      count_next = count + CW'(1);
    end else if (cmd.pop_front) begin
      head_next  = head_inc;
      count_next = count - CW'(1);
    end else if (cmd.pop_back) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_wide[DATA_WIDTH-1:0];
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dump_start) begin
      scan_idx <= '0;
    end else if (cmd.dump_next) begin
      scan_idx <= scan_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result_value <= cmd.from_mem ? rd_wide[VALUE_W-1:0] : '0;
      status       <= cmd.status;
      last         <= cmd.last_scan ? sts.scan_last : 1'b1;
    end
  end

  `DQ_ASSERT(a_count_bound, count <= CW'(DEPTH), "entry count above depth")
  `DQ_ASSERT(a_no_push_full, (cmd.push_front || cmd.push_back) |-> !sts.full,
             "push issued on a full queue")
  `DQ_ASSERT(a_no_pop_empty, (cmd.pop_front || cmd.pop_back || cmd.dump_start) |-> !sts.empty,
             "read issued on an empty queue")

endmodule

`default_nettype wire

[hw/rtl/dq_ctrl.sv]
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  input  wire op_t     operation,
  output logic         req_ready,
  output logic         rsp_valid,
  input  wire logic    rsp_ready,
  input  wire dq_sts_t sts,
  output dq_cmd_t      cmd
);

`include "assert_macros.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state, state_next;
  logic       rsp_valid_next;
  logic       out_free;
  logic       accept;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd        = '0;
    cmd.status = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              cmd.load = 1'b1;
              if (sts.full) begin
                cmd.status = ST_FULL;
              end else begin
                cmd.push_front = (operation == OP_PUSH_FRONT);
                cmd.push_back  = (operation == OP_PUSH_BACK);
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (sts.empty) begin
                cmd.load   = 1'b1;
                cmd.status = ST_EMPTY;
              end else begin
                cmd.pop_front = (operation == OP_POP_FRONT);
                cmd.pop_back  = (operation == OP_POP_BACK);
                state_next    = S_POP;
              end
            end
            OP_READ_ALL: begin
              if (sts.empty) begin
                cmd.load   = 1'b1;
                cmd.status = ST_EMPTY;
              end else begin
                cmd.dump_start = 1'b1;
                state_next     = S_SCAN;
              end
            end
            default: begin
              cmd.load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          cmd.load     = 1'b1;
          cmd.from_mem = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SCAN: begin
        if (out_free) begin
          cmd.load      = 1'b1;
          cmd.from_mem  = 1'b1;
          cmd.last_scan = 1'b1;
          if (sts.scan_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.dump_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rsp_valid_next = cmd.load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  `DQ_ASSERT(a_load_free_slot, cmd.load |-> (!rsp_valid || rsp_ready),
             "output register overwritten before it was taken")
  `DQ_ASSERT(a_scan_not_empty, (state == S_SCAN) |-> !sts.empty,
             "read-out running on an empty queue")

endmodule

`default_nettype wire

[hw/rtl/double_ended_queue.sv]
// Channel    Dir  Payload                          Transaction
// request    in   operation[2:0], value[31:0]      valid && ready
// response   out  result_value[31:0], status[1:0], valid && ready
//                 last
//
// Push, error and unknown operations: result in the output register on the next
// cycle. Pop: registered memory read, then output load; no new request meanwhile.
// Read-all: one response per stored entry, paced by the single read port.
// Reset (rst, synchronous) clears head, count and controller; the entry memory
// is not cleared. A stalled response holds in the output register; the next
// request is taken in the same cycle that register drains.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  dq_in_if.sink     request,
  dq_out_if.source  response
);

  // Command and status between the sequencer and the ring storage.
  dq_cmd_t cmd;
  dq_sts_t sts;

  // Sequencer: owns the handshakes and steps pops and read-outs.
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .operation (request.operation),
    .req_ready (request.ready),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Ring storage: entry memory, head and count, scan index, output payload.
  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (request.value),
    .sts          (sts),
    .result_value (response.result_value),
    .status       (response.status),
    .last         (response.last)
  );

endmodule

`default_nettype wire

[sim/double_ended_queue_test.sv]
module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int DEPTH        = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int RANDOM_ITEMS = 420;
  // Worst case: every transaction a full read-out, every response stalled a while.
  localparam int RUN_LIMIT    = 200000;
  // Longest read-out plus its setup read, with margin.
  localparam int SETTLE       = 80;
  localparam int QUIET_FROM   = 160;
  localparam int QUIET_TO     = 280;

  // Operation codes the block does not define; it must answer them with a plain ok.
  localparam op_t OP_FIRST_UNUSED = op_t'(OP_READ_ALL + 3'd1);
  localparam op_t OP_LAST_UNUSED  = '1;

  typedef struct packed {
    op_t    op;
    value_t value;
  } deque_request_t;

  typedef struct packed {
    value_t  value;
    status_t status;
    logic    last;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst;

  dq_in_if  req_ch ();
  dq_out_if rsp_ch ();

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven, and the responses the deque should give, oldest first.
  deque_request_t request_backlog[$];
  deque_result_t  owed_responses[$];

  // Shadow deque: ring, head and occupancy, updated on each accepted request.
  value_t     shadow_ring[DEPTH];
  logic [5:0] shadow_head;
  logic [6:0] shadow_count;

  // Occupancy seen by the stimulus planner, so fill and drain runs end where they should.
  int plan_count;

  int taken_count;
  int cycle_count;
  int mismatches;

  function automatic logic [5:0] shadow_slot(input int offset);
    return shadow_head + 6'(offset);
  endfunction

  // Apply one accepted request to the shadow deque and queue the responses it owes.
  task automatic shadow_apply(input op_t op, input value_t v);
    deque_result_t r;
    int i;
    r.value  = '0;
    r.status = ST_OK;
    r.last   = 1'b1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            // Head steps back, wrapping below zero to the top of the ring.
            shadow_head = shadow_head - 6'd1;
            shadow_ring[shadow_head] = v;
          end else begin
            shadow_ring[shadow_slot(shadow_count)] = v;
          end
          shadow_count = shadow_count + 7'd1;
        end
        owed_responses.push_back(r);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) begin
            r.value = shadow_ring[shadow_head];
            shadow_head = shadow_head + 6'd1;
          end else begin
            r.value = shadow_ring[shadow_slot(shadow_count - 1)];
          end
          shadow_count = shadow_count - 7'd1;
        end
        owed_responses.push_back(r);
      end
      OP_READ_ALL: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
          owed_responses.push_back(r);
        end else begin
          // One response per entry, front to back, last flag on the back entry.
          for (i = 0; i < shadow_count; i++) begin
            r.value = shadow_ring[shadow_slot(i)];
            r.last  = (i == shadow_count - 1);
            owed_responses.push_back(r);
          end
        end
      end
      default: begin
        owed_responses.push_back(r);
      end
    endcase
  endtask

  // Queue one request for the driver and track occupancy for the planner.
  task automatic plan(input op_t op, input value_t v);
    request_backlog.push_back('{op: op, value: v});
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (plan_count < DEPTH) plan_count++;
      OP_POP_FRONT, OP_POP_BACK:   if (plan_count > 0) plan_count--;
      default: ;
    endcase
  endtask

  // Mostly random words, with the extremes and small corner values now and then.
  function automatic value_t pick_value();
    case ($urandom_range(11))
      0:       return value_t'(32'h7fff_ffff);
      1:       return value_t'(32'h8000_0000);
      2:       return '0;
      3:       return '1;
      default: return value_t'($urandom());
    endcase
  endfunction

  function automatic op_t pick_push();
    return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
  endfunction

  function automatic op_t pick_pop();
    return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  // Stimulus: a directed opening, then fill, drain and mixed runs with random content.
  initial begin
    int target;
    int pick;
    bit first_run;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.operation = OP_PUSH_FRONT;
    req_ch.value   = '0;
    rsp_ch.ready   = 1'b0;
    plan_count     = 0;

    // Every error path on an empty deque, and the undefined operation codes.
    plan(OP_READ_ALL, '0);
    plan(OP_POP_FRONT, '1);
    plan(OP_POP_BACK, '0);
    plan(OP_FIRST_UNUSED, '1);
    plan(op_t'(OP_FIRST_UNUSED + 3'd1), '0);
    plan(OP_LAST_UNUSED, value_t'(32'h8000_0000));
    // Push front from head zero wraps the head to the top of the ring.
    plan(OP_PUSH_FRONT, value_t'(32'h7fff_ffff));
    plan(OP_PUSH_BACK, value_t'(32'h8000_0000));
    plan(OP_PUSH_FRONT, '0);
    plan(OP_PUSH_BACK, '1);
    plan(OP_READ_ALL, '0);
    plan(OP_POP_BACK, '0);
    plan(OP_POP_FRONT, '0);
    plan(OP_READ_ALL, '1);
    plan(OP_POP_FRONT, '0);
    plan(OP_POP_BACK, '0);
    plan(OP_POP_FRONT, '0);
    plan(OP_PUSH_BACK, value_t'(32'h5555_aaaa));
    plan(OP_POP_FRONT, '0);

    target    = request_backlog.size() + RANDOM_ITEMS;
    first_run = 1'b1;
    while (request_backlog.size() < target) begin
      pick      = first_run ? 0 : $urandom_range(9);
      first_run = 1'b0;
      if (pick < 2) begin
        // Fill to the brim, bounce pushes off the full deque, then dump it.
        while (plan_count < DEPTH) plan(pick_push(), pick_value());
        repeat ($urandom_range(3, 1)) plan(pick_push(), pick_value());
        plan(OP_READ_ALL, pick_value());
      end else if (pick < 4) begin
        // Drain from both ends, then pop and dump on empty.
        while (plan_count > 0) plan(pick_pop(), pick_value());
        repeat ($urandom_range(2, 1)) plan(pick_pop(), pick_value());
        plan(OP_READ_ALL, pick_value());
      end else begin
        // Mixed traffic around a shallow fill level.
        repeat ($urandom_range(40, 20)) begin
          pick = $urandom_range(99);
          if (pick < 42)      plan(pick_push(), pick_value());
          else if (pick < 78) plan(pick_pop(), pick_value());
          else if (pick < 90) plan(OP_READ_ALL, pick_value());
          else if (pick < 95) plan(op_t'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED)),
                                   pick_value());
          else                plan(pick_push(), pick_value());
        end
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for the driver to hand over every request, then for every owed response.
    while (request_backlog.size() != 0 || req_ch.valid) @(posedge clk);
    while (owed_responses.size() != 0) @(posedge clk);
    // Leave room for any stray response still on its way.
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

  // Driver: advance to the next request once the current one is taken; idle now and then.
  always @(posedge clk) begin : request_driver
    bit hold;
    hold = !(taken_count >= QUIET_FROM && taken_count < QUIET_TO) &&
           ($urandom_range(99) < 8);
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (request_backlog.size() != 0 && !hold) begin
        deque_request_t nxt;
        nxt = request_backlog.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.operation <= nxt.op;
        req_ch.value     <= nxt.value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response sink: stall at random, except through the quiet stretch.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= (taken_count >= QUIET_FROM && taken_count < QUIET_TO) ||
                      ($urandom_range(99) >= 8);
    end
  end

  // Monitor: feed accepted requests to the shadow deque, check each response transaction.
  always @(posedge clk) begin : monitor
    deque_result_t want;
    if (rst) begin
      shadow_head  = '0;
      shadow_count = '0;
      taken_count <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        shadow_apply(req_ch.operation, req_ch.value);
        taken_count <= taken_count + 1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_responses.size() == 0) begin
          $display("%0t: unexpected response: value %0d status %0d last %0b", $time,
                   rsp_ch.result_value, rsp_ch.status, rsp_ch.last);
          mismatches++;
        end else begin
          want = owed_responses.pop_front();
          if (rsp_ch.result_value !== want.value) begin
            $display("%0t: result_value expected %0d actual %0d", $time,
                     want.value, rsp_ch.result_value);
            mismatches++;
          end
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, rsp_ch.status);
            mismatches++;
          end
          if (rsp_ch.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_ch.last);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("double_ended_queue verification failed");
      $finish;
    end
  end

  initial mismatches = 0;

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/dq_pkg.sv
hw/rtl/dq_if.sv
hw/rtl/dq_datapath.sv
hw/rtl/dq_ctrl.sv
hw/rtl/double_ended_queue.sv
sim/double_ended_queue_test.sv
